### rtl/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// shared types and constants of the scanned segment display driver
// ----------------------------------------------------------------------------
package ssd_pkg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_PATTERN = 3'd1,
        OP_HIDE    = 3'd2,
        OP_NORMAL  = 3'd3,
        OP_BLINK   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CFG_DIGITS = 2'd0,
        CFG_SCAN   = 2'd1,
        CFG_PERIOD = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        DS_NORMAL = 2'd0,
        DS_HIDDEN = 2'd1,
        DS_BLINK  = 2'd2
    } disp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APPLY,
        S_DIV,
        S_EMIT
    } state_t;

    localparam logic [31:0] RESET_BLINK  = 32'd1000;
    localparam logic [31:0] RESET_PERIOD = 32'd2;
    localparam logic [3:0]  RESET_DIGITS = 4'd8;

    typedef struct packed {
        logic [2:0]  operation;
        logic [3:0]  digit;
        logic [31:0] value;
    } in_t;

    typedef struct packed {
        logic [2:0]  digit_index;
        logic [31:0] segments;
        logic        last;
    } out_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture item, advance time
        logic apply;      // apply setting at current index
        logic div_start;  // start phase division for current index
        logic emit;       // drive result at current index
        logic step;       // advance index
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_tick;
        logic is_set;
        logic scan;
        logic scan_due;
        logic need_div;
        logic div_done;
        logic at_end;
    } sts_t;

endpackage

### rtl/ssd_ctrl.sv
// ----------------------------------------------------------------------------
// ssd_ctrl
// sequencer: walks digits for settings and drive words
// ----------------------------------------------------------------------------
module ssd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ssd_pkg::sts_t sts,
    output ssd_pkg::cmd_t cmd
);

    ssd_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssd_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssd_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = ssd_pkg::S_APPLY;
                end
            end
            ssd_pkg::S_APPLY:
            begin
                // item registered; decide path
                if (sts.is_set)
                begin
                    if (sts.at_end)
                    begin
                        state_next = ssd_pkg::S_IDLE;
                    end
                end
                else if (sts.is_tick && (!sts.scan || sts.scan_due))
                begin
                    state_next = ssd_pkg::S_DIV;
                end
                else
                begin
                    state_next = ssd_pkg::S_IDLE;
                end
            end
            ssd_pkg::S_DIV:
            begin
                if (!sts.need_div || sts.div_done)
                begin
                    state_next = ssd_pkg::S_EMIT;
                end
            end
            ssd_pkg::S_EMIT:
            begin
                state_next = sts.at_end ? ssd_pkg::S_IDLE : ssd_pkg::S_DIV;
            end
            default:
            begin
                state_next = ssd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ssd_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ssd_pkg::S_APPLY:
            begin
                cmd.apply = sts.is_set;
                cmd.step  = sts.is_set;
            end
            ssd_pkg::S_DIV:
            begin
                cmd.div_start = 1'b1;
            end
            ssd_pkg::S_EMIT:
            begin
                cmd.emit = 1'b1;
                cmd.step = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_emit_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ssd_pkg::S_EMIT |-> $past(state_reg) == ssd_pkg::S_DIV)
        else $error("emit without division phase");
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after start");
    a_no_emit_on_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !cmd.apply)
        else $error("emit and apply together");
`endif

endmodule

### rtl/ssd_div.sv
// ----------------------------------------------------------------------------
// ssd_div
// restoring divider returning the quotient parity, one bit per cycle
// ----------------------------------------------------------------------------
module ssd_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic        odd
);

    logic [31:0] quo_reg, quo_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [32:0] trial;

    assign trial = {rem_reg[31:0], quo_reg[31]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (!run_reg && go && !done_reg)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = 6'd0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (!run_reg && go)
        begin
            dvs_reg <= (divisor == 32'd0) ? 32'd1 : divisor;
        end
    end

    assign done = done_reg;
    assign odd  = quo_reg[0];

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("division done held");
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(run_reg))
        else $error("done without running");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> cnt_reg <= 6'd31)
        else $error("divider count overrun");
`endif

endmodule

### rtl/ssd_dp.sv
// ----------------------------------------------------------------------------
// ssd_dp
// datapath: config, time, per-digit tables, phase divider, result register
// ----------------------------------------------------------------------------
module ssd_dp #(
    parameter int MAX_DIGITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ssd_pkg::in_t  in_item,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    input  ssd_pkg::cmd_t cmd,
    output ssd_pkg::sts_t sts,
    output ssd_pkg::out_t result,
    output logic          result_valid
);

    localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int NW = $clog2(MAX_DIGITS + 1);

    logic [3:0]  digits_reg;
    logic        scan_reg;
    logic [31:0] period_reg;
    logic [31:0] time_reg;
    logic [31:0] lst_reg;
    logic [IW-1:0] pos_reg;

    logic [31:0] pat_reg   [MAX_DIGITS];
    logic [1:0]  disp_reg  [MAX_DIGITS];
    logic [31:0] blink_reg [MAX_DIGITS];

    ssd_pkg::in_t item_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] hi_reg;   // last index to visit
    logic          skip_reg; // setting targets no digit

    logic [NW-1:0] n;
    logic [3:0]    d;
    logic          div_done, div_odd, div_go;
    logic [31:0]   elapsed;
    logic [31:0]   time_sum;
    logic          set_op;
    logic          tick_op;
    logic [IW-1:0] scan_pos;
    logic [IW-1:0] drv;

    always_comb
    begin
        if (digits_reg == 4'd0)
        begin
            n = NW'(1);
        end
        else if (32'(digits_reg) > 32'(MAX_DIGITS))
        begin
            n = NW'(MAX_DIGITS);
        end
        else
        begin
            n = NW'(digits_reg);
        end
    end

    assign d        = in_item.digit;
    assign time_sum = time_reg + in_item.value;
    assign elapsed  = time_reg - lst_reg;
    assign tick_op  = (item_reg.operation == ssd_pkg::OP_TICK);
    assign set_op   = (item_reg.operation == ssd_pkg::OP_PATTERN)
                   || (item_reg.operation == ssd_pkg::OP_HIDE)
                   || (item_reg.operation == ssd_pkg::OP_NORMAL)
                   || ((item_reg.operation == ssd_pkg::OP_BLINK) && (item_reg.value != 32'd0));
    assign scan_pos = (32'(pos_reg) >= 32'(n)) ? '0 : pos_reg;

    // control, config and time state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg   <= ssd_pkg::RESET_DIGITS;
            scan_reg     <= 1'b0;
            period_reg   <= ssd_pkg::RESET_PERIOD;
            time_reg     <= '0;
            lst_reg      <= '0;
            pos_reg      <= '0;
            idx_reg      <= '0;
            hi_reg       <= '0;
            skip_reg     <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            result_valid <= cmd.emit;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ssd_pkg::CFG_DIGITS: digits_reg <= cfg_data[3:0];
                    ssd_pkg::CFG_SCAN:
                    begin
                        scan_reg <= cfg_data[0];
                        if (cfg_data[0])
                        begin
                            lst_reg <= time_reg;
                            pos_reg <= '0;
                        end
                    end
                    ssd_pkg::CFG_PERIOD: period_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.load)
            begin
                if (in_item.operation == ssd_pkg::OP_TICK)
                begin
                    time_reg <= time_sum;
                end
                if (in_item.operation != ssd_pkg::OP_TICK)
                begin
                    skip_reg <= (d != 4'd0) && (32'(d) > 32'(n));
                    idx_reg  <= (d == 4'd0) ? '0 : IW'(d - 4'd1);
                    hi_reg   <= (d == 4'd0) ? IW'(n - NW'(1)) : IW'(d - 4'd1);
                end
                else
                begin
                    skip_reg <= 1'b0;
                    idx_reg  <= '0;
                    hi_reg   <= IW'(n - NW'(1));
                end
            end
            if (cmd.emit && scan_reg)
            begin
                lst_reg <= lst_reg + period_reg;
                pos_reg <= (32'(scan_pos) + 1 >= 32'(n)) ? '0 : scan_pos + IW'(1);
            end
            if (cmd.step)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
        end
    end

    // item register and per-digit tables
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
            begin
                pat_reg[i]   <= '0;
                disp_reg[i]  <= ssd_pkg::DS_NORMAL;
                blink_reg[i] <= ssd_pkg::RESET_BLINK;
            end
        end
        else if (cmd.apply && !skip_reg)
        begin
            case (item_reg.operation)
                ssd_pkg::OP_PATTERN: pat_reg[idx_reg] <= item_reg.value;
                ssd_pkg::OP_HIDE:    disp_reg[idx_reg] <= ssd_pkg::DS_HIDDEN;
                ssd_pkg::OP_NORMAL:  disp_reg[idx_reg] <= ssd_pkg::DS_NORMAL;
                ssd_pkg::OP_BLINK:
                begin
                    disp_reg[idx_reg]  <= ssd_pkg::DS_BLINK;
                    blink_reg[idx_reg] <= item_reg.value;
                end
                default: ;
            endcase
        end
    end

    // digit being driven: scan position in scan mode, else running index
    assign drv = scan_reg ? scan_pos : idx_reg;

    assign div_go = cmd.div_start && (disp_reg[drv] == ssd_pkg::DS_BLINK);

    ssd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go),
        .dividend (time_reg),
        .divisor  (blink_reg[drv]),
        .done     (div_done),
        .odd      (div_odd)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result.digit_index <= 3'(drv);
            if (disp_reg[drv] == ssd_pkg::DS_HIDDEN)
            begin
                result.segments <= '0;
            end
            else if (disp_reg[drv] == ssd_pkg::DS_BLINK && div_odd)
            begin
                result.segments <= '0;
            end
            else
            begin
                result.segments <= pat_reg[drv];
            end
            result.last <= scan_reg || (idx_reg == hi_reg);
        end
    end

    always_comb
    begin
        sts.is_tick  = tick_op;
        sts.is_set   = set_op;
        sts.scan     = scan_reg;
        sts.scan_due = elapsed >= period_reg;
        sts.need_div = (disp_reg[drv] == ssd_pkg::DS_BLINK);
        sts.div_done = div_done;
        // settings walk their digits in either mode
        sts.at_end   = skip_reg || (scan_reg && tick_op) || (idx_reg == hi_reg);
    end

`ifndef SYNTHESIS
    a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(cmd.emit))
        else $error("result without emit");
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(idx_reg) < 32'(MAX_DIGITS))
        else $error("index out of range");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pos_reg) < 32'(MAX_DIGITS))
        else $error("scan position out of range");
`endif

endmodule

### rtl/segment_display_scan_blink.sv
// ----------------------------------------------------------------------------
// segment_display_scan_blink
// multiplexed segment display driver with per-digit hide and blink
// ----------------------------------------------------------------------------
// command channel: item taken when start is high and busy is low
// config channel: cfg_valid/cfg_ready with cfg_index and cfg_data; ready
//   is always high, write only while idle
// result channel: result_valid strobes for one cycle per drive word; the
//   receiver cannot stall, every strobe is a transfer
// a setting item is applied to each digit touched in turn, in the apply state
// a tick in static mode gives one word per digit in use; each digit passes
//   the division and emit states, and a blinking digit waits in the division
//   state for its quotient parity division
// a scan tick gives at most one word, through the same states
// a tick's first word passes the apply, division and emit states before it is registered
// reset: 8 digits, static mode, scan period 2, patterns zero, all normal,
//   blink periods 1000, time zero
// ----------------------------------------------------------------------------
module segment_display_scan_blink #(
    parameter int MAX_DIGITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ssd_pkg::in_t  item,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    output logic          result_valid,
    output ssd_pkg::out_t result
);

    ssd_pkg::cmd_t cmd;
    ssd_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    ssd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    ssd_dp #(.MAX_DIGITS(MAX_DIGITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_item      (item),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

### test/tb_segment_display_scan_blink.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_segment_display_scan_blink
// self-checking bench for the scanned segment display driver
// ----------------------------------------------------------------------------
// items are queued by an initial block and driven by a clocked driver; each
// accepted item is run through a behavioral copy of the display state that
// queues the expected drive words; a clocked monitor compares every result
// strobe with the oldest expected word. runs through static and scan modes,
// several digit counts and scan periods, with random gaps on the command side
// ----------------------------------------------------------------------------
module tb_segment_display_scan_blink;

    localparam int NDIG = 8;
    localparam int IDLE_LIMIT = 20000;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    ssd_pkg::in_t  item;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [1:0]    cfg_index;
    logic [31:0]   cfg_data;
    logic          result_valid;
    ssd_pkg::out_t result;

    segment_display_scan_blink u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    // display state shadow
    logic [3:0]     sh_digits;
    logic           sh_scan;
    logic [31:0]    sh_period;
    logic [31:0]    sh_time;
    logic [31:0]    sh_last_scan;
    logic [2:0]     sh_pos;
    logic [31:0]    sh_pattern [NDIG];
    ssd_pkg::disp_t sh_state [NDIG];
    logic [31:0]    sh_blink [NDIG];

    ssd_pkg::in_t  pending_items [$];
    ssd_pkg::out_t expected_words [$];
    int   mismatches;
    int   idle_cycles;
    int   idle_pct;

    always #2 clk = ~clk;

    function automatic int live_digits();
        if (sh_digits == 0) return 1;
        if (sh_digits > NDIG) return NDIG;
        return sh_digits;
    endfunction

    function automatic logic [31:0] drive_segments(int idx);
        logic [31:0] p;
        if (sh_state[idx] == ssd_pkg::DS_HIDDEN) return 32'd0;
        if (sh_state[idx] == ssd_pkg::DS_BLINK)
        begin
            p = (sh_blink[idx] == 0) ? 32'd1 : sh_blink[idx];
            if ((sh_time / p) & 32'd1) return 32'd0;
        end
        return sh_pattern[idx];
    endfunction

    task automatic write_shadow_reg(ssd_pkg::cfg_idx_t idx, logic [31:0] data);
        case (idx)
            ssd_pkg::CFG_DIGITS: sh_digits = data[3:0];
            ssd_pkg::CFG_SCAN:
            begin
                sh_scan = data[0];
                if (data[0])
                begin
                    sh_last_scan = sh_time;
                    sh_pos = 3'd0;
                end
            end
            ssd_pkg::CFG_PERIOD: sh_period = data;
            default: ;
        endcase
    endtask

    task automatic predict_drive_words(ssd_pkg::in_t it);
        int n;
        int lo;
        int hi;
        int pos;
        ssd_pkg::out_t w;
        n = live_digits();
        if (it.operation inside {ssd_pkg::OP_PATTERN, ssd_pkg::OP_HIDE,
                                 ssd_pkg::OP_NORMAL, ssd_pkg::OP_BLINK})
        begin
            if (it.operation == ssd_pkg::OP_BLINK && it.value == 0) return;
            if (it.digit == 0)
            begin
                lo = 0;
                hi = n;
            end
            else
            begin
                if (it.digit - 1 >= n) return;
                lo = it.digit - 1;
                hi = it.digit;
            end
            for (int i = lo; i < hi; i++)
            begin
                case (it.operation)
                    ssd_pkg::OP_PATTERN: sh_pattern[i] = it.value;
                    ssd_pkg::OP_HIDE:    sh_state[i] = ssd_pkg::DS_HIDDEN;
                    ssd_pkg::OP_NORMAL:  sh_state[i] = ssd_pkg::DS_NORMAL;
                    default:
                    begin
                        sh_state[i] = ssd_pkg::DS_BLINK;
                        sh_blink[i] = it.value;
                    end
                endcase
            end
            return;
        end
        if (it.operation != ssd_pkg::OP_TICK) return;
        sh_time = sh_time + it.value;
        if (!sh_scan)
        begin
            for (int i = 0; i < n; i++)
            begin
                w.digit_index = i[2:0];
                w.segments = drive_segments(i);
                w.last = (i + 1 == n);
                expected_words.push_back(w);
            end
            return;
        end
        if (32'(sh_time - sh_last_scan) < sh_period) return;
        sh_last_scan = sh_last_scan + sh_period;
        pos = (sh_pos >= n) ? 0 : sh_pos;
        sh_pos = (pos + 1 >= n) ? 3'd0 : 3'(pos + 1);
        w.digit_index = pos[2:0];
        w.segments = drive_segments(pos);
        w.last = 1'b1;
        expected_words.push_back(w);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (start && !busy)
                predict_drive_words(item);
            if (!(start && busy))
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    start <= 1'b1;
                    item <= pending_items.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected drive word idx=%0d seg=%h last=%0b",
                             result.digit_index, result.segments, result.last);
            end
            else if (result !== expected_words[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch exp idx=%0d seg=%h last=%0b got idx=%0d seg=%h last=%0b",
                             expected_words[0].digit_index, expected_words[0].segments,
                             expected_words[0].last, result.digit_index,
                             result.segments, result.last);
                void'(expected_words.pop_front());
            end
            else
                void'(expected_words.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (!rst_n || result_valid || (start && !busy) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("FAIL segment_display_scan_blink");
            $finish;
        end
    end

    task automatic queue_item(ssd_pkg::op_t op, logic [3:0] dig, logic [31:0] val);
        ssd_pkg::in_t it;
        it.operation = op;
        it.digit = dig;
        it.value = val;
        pending_items.push_back(it);
    endtask

    task automatic wait_drained();
        while (pending_items.size() > 0 || start || busy || expected_words.size() > 0)
            @(posedge clk);
        repeat (320) @(posedge clk);
    endtask

    task automatic write_reg(ssd_pkg::cfg_idx_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        write_shadow_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic queue_random(int count);
        logic [31:0] v;
        int r;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            case ($urandom_range(3))
                0: v = $urandom;
                1: v = $urandom_range(40);
                2: v = 32'hFFFF_FFFF - $urandom_range(3);
                default: v = $urandom_range(3000);
            endcase
            if (r < 45)
                queue_item(ssd_pkg::OP_TICK, 4'($urandom_range(15)),
                           ($urandom_range(9) == 0) ? $urandom : $urandom_range(600));
            else if (r < 60)
                queue_item(ssd_pkg::OP_PATTERN, 4'($urandom_range(8)), $urandom);
            else if (r < 70)
                queue_item(ssd_pkg::OP_HIDE, 4'($urandom_range(9)), $urandom);
            else if (r < 80)
                queue_item(ssd_pkg::OP_NORMAL, 4'($urandom_range(9)), $urandom);
            else if (r < 95)
                queue_item(ssd_pkg::OP_BLINK, 4'($urandom_range(9)),
                           ($urandom_range(15) == 0) ? 32'd0 : v);
            else
            begin
                ssd_pkg::in_t it;
                it.operation = 3'($urandom_range(7, 5));
                it.digit = 4'($urandom_range(15));
                it.value = $urandom;
                pending_items.push_back(it);
            end
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        idle_pct = 13;
        sh_digits = ssd_pkg::RESET_DIGITS;
        sh_scan = 1'b0;
        sh_period = ssd_pkg::RESET_PERIOD;
        sh_time = '0;
        sh_last_scan = '0;
        sh_pos = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            sh_pattern[i] = '0;
            sh_state[i] = ssd_pkg::DS_NORMAL;
            sh_blink[i] = ssd_pkg::RESET_BLINK;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, all operations and edge cases
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd0);
        queue_item(ssd_pkg::OP_PATTERN, 4'd0, 32'hFFFF_FFFF);
        queue_item(ssd_pkg::OP_PATTERN, 4'd8, 32'h5555_AAAA);
        queue_item(ssd_pkg::OP_PATTERN, 4'd9, 32'h1234_5678);
        queue_item(ssd_pkg::OP_PATTERN, 4'd15, 32'h0);
        queue_item(ssd_pkg::OP_HIDE, 4'd2, 32'h0);
        queue_item(ssd_pkg::OP_BLINK, 4'd3, 32'd0);
        queue_item(ssd_pkg::OP_BLINK, 4'd4, 32'd1);
        queue_item(ssd_pkg::OP_BLINK, 4'd5, 32'hFFFF_FFFF);
        queue_item(ssd_pkg::OP_BLINK, 4'd1, 32'd3);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd1);
        queue_item(ssd_pkg::op_t'(3'd5), 4'd0, 32'hFFFF_FFFF);
        queue_item(ssd_pkg::op_t'(3'd7), 4'd8, 32'h0);
        queue_item(ssd_pkg::OP_TICK, 4'd15, 32'hFFFF_FFFF);
        queue_item(ssd_pkg::OP_NORMAL, 4'd2, 32'h0);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd7);
        wait_drained();

        // one digit, then scan with zero and large periods
        write_reg(ssd_pkg::CFG_DIGITS, 32'd0);
        queue_item(ssd_pkg::OP_PATTERN, 4'd2, 32'hDEAD_BEEF);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd5);
        wait_drained();
        write_reg(ssd_pkg::CFG_DIGITS, 32'd15);
        write_reg(ssd_pkg::CFG_PERIOD, 32'd0);
        write_reg(ssd_pkg::CFG_SCAN, 32'd1);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd0);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd0);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd1);
        wait_drained();
        write_reg(ssd_pkg::CFG_PERIOD, 32'hFFFF_FFFF);
        write_reg(ssd_pkg::CFG_SCAN, 32'd1);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'hFFFF_FFFE);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd1);
        queue_item(ssd_pkg::OP_TICK, 4'd0, 32'd9);
        wait_drained();

        // random phases across settings
        for (int ph = 0; ph < 8; ph++)
        begin
            idle_pct = (ph == 3) ? 0 : 13;
            write_reg(ssd_pkg::CFG_DIGITS,
                      $urandom_range(ph == 0 ? 8 : 0, ph == 1 ? 1 : 15));
            write_reg(ssd_pkg::CFG_PERIOD,
                      (ph == 5) ? $urandom : $urandom_range(ph % 3, 400));
            write_reg(ssd_pkg::CFG_SCAN, {31'd0, ph[0]});
            queue_random(45);
            wait_drained();
        end

        if (mismatches == 0)
            $display("PASS segment_display_scan_blink");
        else
            $display("FAIL segment_display_scan_blink");
        $finish;
    end

endmodule
